// File: hw/rtl/lpfr_pkg.sv
package lpfr_pkg;

    // fixed field widths on the ports
    localparam int PAGE_W      = 16;
    localparam int FRAME_IDX_W = 3;
    localparam int CFG_W       = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    // widest slot index over the supported frame counts (up to 64)
    localparam int MAX_SLOT_W  = 6;

    // frame count after reset
    localparam int ACTIVE_RESET = 8;

    // recency update command from the sequencer to the rank block
    typedef struct packed {
        logic                  en;
        logic                  clear;
        logic                  set_valid;
        logic                  age_all;
        logic [MAX_SLOT_W-1:0] slot;
        logic [MAX_SLOT_W-1:0] limit;
    } lpfr_upd_t;

endpackage

// File: hw/rtl/lpfr_page_store.sv
module lpfr_page_store #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // a read and a write to the same entry at one edge returns the new data
    always_ff @(posedge aclk) begin
        fwd_reg      <= we && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// File: hw/rtl/lpfr_recency.sv
module lpfr_recency
    import lpfr_pkg::*;
#(
    parameter int FRAME_SLOTS = 8,
    parameter int SLOT_W      = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lpfr_upd_t              upd,
    input  logic [SLOT_W-1:0]      rd_idx,
    output logic                   valid_at,
    output logic [SLOT_W-1:0]      rank_at,
    output logic [FRAME_SLOTS-1:0] valid_vec
);

    logic [FRAME_SLOTS-1:0] valid_reg;
    logic [FRAME_SLOTS-1:0] valid_next;
    logic [SLOT_W-1:0]      rank_reg  [FRAME_SLOTS];
    logic [SLOT_W-1:0]      rank_next [FRAME_SLOTS];
    logic [SLOT_W-1:0]      upd_slot;
    logic [SLOT_W-1:0]      upd_limit;

    assign upd_slot  = upd.slot[SLOT_W-1:0];
    assign upd_limit = upd.limit[SLOT_W-1:0];

    // frames update in parallel: touched one newest; younger ones age, all if age_all
    always_comb begin
        for (int k = 0; k < FRAME_SLOTS; k++) begin
            valid_next[k] = valid_reg[k];
            rank_next[k]  = rank_reg[k];
            if (upd.clear) begin
                valid_next[k] = 1'b0;
                rank_next[k]  = '0;
            end else if (upd.en) begin
                if (upd_slot == SLOT_W'(k)) begin
                    rank_next[k] = '0;
                    if (upd.set_valid) begin
                        valid_next[k] = 1'b1;
                    end
                end else if (valid_reg[k] && (upd.age_all || rank_reg[k] < upd_limit)) begin
                    rank_next[k] = rank_reg[k] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int k = 0; k < FRAME_SLOTS; k++) begin
                rank_reg[k] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int k = 0; k < FRAME_SLOTS; k++) begin
                rank_reg[k] <= rank_next[k];
            end
        end
    end

    assign valid_at  = valid_reg[rd_idx];
    assign rank_at   = rank_reg[rd_idx];
    assign valid_vec = valid_reg;

endmodule

// File: hw/rtl/lru_page_frame_replacer.sv
// LRU page frame replacer.
// s_ channel: one page reference per transaction, page number in s_tdata, s_tlast marks
// the final reference of a string; the frames are emptied after that reference.
// m_ channel: one result per reference: hit or fault, frame used, evicted page, and
// s_tlast echoed on m_tlast.
// cfg channel: writes active_frames (0 acts as 1, values above FRAME_SLOTS saturate);
// every write also empties all frames. Write it only while no reference is in flight.
// Timing: the page store has one read port and the scan reads one frame per cycle over
// the active frames, then the update state writes the page store on a fault and updates
// all ranks in parallel. The next reference is accepted in the update state, once the
// output register is free.
// Reset empties all frames and sets active_frames to 8 (or FRAME_SLOTS if smaller).
// The result sits in an output register; if m_tready is low while a second result is
// ready, the update cycle holds and s_tready stays low until the register frees up.
module lru_page_frame_replacer
    import lpfr_pkg::*;
#(
    parameter int FRAME_SLOTS = 8,
    parameter int PAGE_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // active_frames
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [15:0] page_number
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [2:0] frame_index, [18:3] evicted_page, rest 0
    output logic [M_TUSER_W-1:0] m_tuser,    // [0] hit, [1] evicted_valid
    output logic                 m_tlast
);

    localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int RESET_FRAMES = (FRAME_SLOTS < ACTIVE_RESET) ? FRAME_SLOTS : ACTIVE_RESET;
    localparam logic [SLOT_W-1:0] LAST_IDX_RST = SLOT_W'(RESET_FRAMES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    last_idx_reg;
    logic [SLOT_W-1:0]    last_idx_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 last_reg;
    logic                 hit_found_reg;
    logic [SLOT_W-1:0]    hit_slot_reg;
    logic [SLOT_W-1:0]    hit_rank_reg;
    logic                 empty_found_reg;
    logic [SLOT_W-1:0]    empty_slot_reg;
    logic [SLOT_W-1:0]    old_slot_reg;
    logic [SLOT_W-1:0]    old_rank_reg;
    logic [PAGE_BITS-1:0] old_page_reg;

    logic                   m_valid_reg;
    logic                   m_hit_reg;
    logic [FRAME_IDX_W-1:0] m_frame_reg;
    logic                   m_ev_valid_reg;
    logic [PAGE_W-1:0]      m_ev_page_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   cfg_wr;
    logic                   out_free;
    logic                   upd_go;
    logic                   scan_last;
    logic [SLOT_W-1:0]      rd_addr;
    logic [PAGE_BITS-1:0]   page_rd;
    logic                   valid_at;
    logic [SLOT_W-1:0]      rank_at;
    logic [FRAME_SLOTS-1:0] valid_vec;
    logic [SLOT_W-1:0]      slot_sel;
    logic                   evict;
    lpfr_upd_t              upd;

    assign out_free  = !m_valid_reg || m_tready;
    assign upd_go    = (state_reg == ST_UPDATE) && out_free;
    assign s_tready  = (state_reg == ST_IDLE) || upd_go;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign scan_last = (idx_reg == last_idx_reg);

    // entry 0 is read whenever no scan runs, so the scan starts with its data
    assign rd_addr = ((state_reg == ST_SCAN) && !scan_last) ? idx_reg + 1'b1 : '0;

    always_comb begin
        if (cfg_data == '0) begin
            last_idx_next = '0;
        end else if (int'(cfg_data) > FRAME_SLOTS) begin
            last_idx_next = SLOT_W'(FRAME_SLOTS - 1);
        end else begin
            last_idx_next = SLOT_W'(int'(cfg_data) - 1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end else if (upd_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_idx_reg <= LAST_IDX_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                last_idx_reg <= last_idx_next;
            end
        end
    end

    // scan: one frame per cycle, first hit, first empty frame and oldest frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (s_accept) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            if (!hit_found_reg && valid_at && (page_rd == page_reg)) begin
                hit_found_reg <= 1'b1;
            end
            if (!empty_found_reg && !valid_at) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx_reg  <= '0;
            page_reg <= PAGE_BITS'(s_tdata);
            last_reg <= s_tlast;
        end else if (state_reg == ST_SCAN) begin
            if (!scan_last) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (!hit_found_reg && valid_at && (page_rd == page_reg)) begin
                hit_slot_reg <= idx_reg;
                hit_rank_reg <= rank_at;
            end
            if (!empty_found_reg && !valid_at) begin
                empty_slot_reg <= idx_reg;
            end
            if ((idx_reg == '0) || (rank_at > old_rank_reg)) begin
                old_slot_reg <= idx_reg;
                old_rank_reg <= rank_at;
                old_page_reg <= page_rd;
            end
        end
    end

    assign evict = !hit_found_reg && !empty_found_reg;

    always_comb begin
        if (hit_found_reg) begin
            slot_sel = hit_slot_reg;
        end else if (empty_found_reg) begin
            slot_sel = empty_slot_reg;
        end else begin
            slot_sel = old_slot_reg;
        end
    end

    always_comb begin
        upd.en        = upd_go;
        upd.clear     = (upd_go && last_reg) || cfg_wr;
        upd.set_valid = !hit_found_reg;
        upd.age_all   = !hit_found_reg;
        upd.slot      = MAX_SLOT_W'(slot_sel);
        upd.limit     = MAX_SLOT_W'(hit_rank_reg);
    end

    lpfr_page_store #(
        .DEPTH (FRAME_SLOTS),
        .WIDTH (PAGE_BITS),
        .AW    (SLOT_W)
    ) u_page_store (
        .aclk    (aclk),
        .we      (upd_go && !hit_found_reg),
        .wr_addr (slot_sel),
        .wr_data (page_reg),
        .rd_addr (rd_addr),
        .rd_data (page_rd)
    );

    lpfr_recency #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_recency (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .rd_idx    (idx_reg),
        .valid_at  (valid_at),
        .rank_at   (rank_at),
        .valid_vec (valid_vec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (upd_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            m_hit_reg      <= hit_found_reg;
            m_frame_reg    <= FRAME_IDX_W'(slot_sel);
            m_ev_valid_reg <= evict;
            m_ev_page_reg  <= evict ? PAGE_W'(old_page_reg) : '0;
            m_last_reg     <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PAGE_W - FRAME_IDX_W){1'b0}}, m_ev_page_reg, m_frame_reg};
    assign m_tuser  = {m_ev_valid_reg, m_hit_reg};
    assign m_tlast  = m_last_reg;

    // a hit always refers to a frame that holds a page
    a_hit_on_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go && hit_found_reg |-> valid_vec[hit_slot_reg])
        else $error("hit reported on an empty frame");

    // after the final reference of a string every frame is empty
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go && last_reg |=> (valid_vec == '0))
        else $error("frames not emptied after last reference");

    // eviction only happens on a fault
    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("eviction reported on a hit");

endmodule

// File: bench/tb_lru_page_frame_replacer.sv
`timescale 1ns / 1ps

module tb_lru_page_frame_replacer;
    import lpfr_pkg::*;

    localparam int SLOTS = 8;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last;
    } page_ref_t;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_W-1:0]      ev_page;
        logic                   last;
    } lru_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // [15:0] page_number
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [2:0] frame_index, [18:3] evicted_page, rest 0
    logic [M_TUSER_W-1:0] m_tuser;         // [0] hit, [1] evicted_valid
    logic                 m_tlast;

    page_ref_t   pending_refs[$];
    lru_result_t expected_results[$];
    int          errors = 0;
    logic        quiet = 1'b0;

    // frame table as the testbench sees it
    logic [PAGE_W-1:0] res_page[SLOTS];
    logic              res_valid[SLOTS];
    logic [2:0]        res_age[SLOTS];
    logic [CFG_W-1:0]  frames_cfg;

    lru_page_frame_replacer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void empty_frames();
        for (int k = 0; k < SLOTS; k++) begin
            res_page[k]  = '0;
            res_valid[k] = 1'b0;
            res_age[k]   = '0;
        end
    endfunction

    function automatic lru_result_t lru_reference(input logic [PAGE_W-1:0] page,
                                                  input logic last);
        lru_result_t r;
        int n, slot, oldest, limit;
        logic found, empty;
        r = '0;
        r.last = last;
        slot = 0;
        found = 1'b0;
        empty = 1'b0;
        n = (frames_cfg == 0) ? 1 : ((frames_cfg > SLOTS) ? SLOTS : int'(frames_cfg));
        for (int k = 0; k < n; k++) begin
            if (res_valid[k] && res_page[k] == page) begin
                found = 1'b1;
                slot = k;
                break;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            limit = res_age[slot];
        end else begin
            limit = SLOTS + 1;
            for (int k = 0; k < n; k++) begin
                if (!res_valid[k]) begin
                    empty = 1'b1;
                    slot = k;
                    break;
                end
            end
            if (!empty) begin
                // no empty frame left: evict the oldest one
                oldest = 0;
                for (int k = 1; k < n; k++)
                    if (res_age[k] > res_age[oldest])
                        oldest = k;
                slot = oldest;
                r.ev_valid = 1'b1;
                r.ev_page = res_page[slot];
            end
            res_valid[slot] = 1'b1;
            res_page[slot] = page;
        end
        for (int k = 0; k < n; k++)
            if (k != slot && res_valid[k] && res_age[k] < limit)
                res_age[k] = res_age[k] + 3'd1;
        res_age[slot] = '0;
        r.frame = slot[FRAME_IDX_W-1:0];
        if (last)
            empty_frames();
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // driver: offers queued references, predicts on every accepted transaction
    int src_gap = 0;
    always @(posedge aclk) begin
        page_ref_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(lru_reference(s_tdata, s_tlast));
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_refs.size() != 0) begin
                if (!quiet && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else begin
                    item = pending_refs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.page;
                    s_tlast <= item.last;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long back-pressure so the block fills up and stalls its input
    int hold_left = 0;
    int results_seen = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                results_seen <= results_seen + 1;
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (m_tvalid && m_tready && (results_seen == 299 || results_seen == 1199))
                hold_left <= 400;
        end
    end

    // monitor: checks results and drives m_tready
    int sink_stall = 0;
    always @(posedge aclk) begin
        lru_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0h/%0h/%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
                    check_field("evicted_valid", 32'(want.ev_valid), 32'(m_tuser[1]));
                    check_field("frame_index", 32'(want.frame), 32'(m_tdata[2:0]));
                    check_field("evicted_page", 32'(want.ev_page), 32'(m_tdata[18:3]));
                    check_field("tdata padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:19]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_ref(input logic [PAGE_W-1:0] page, input logic last);
        page_ref_t item;
        item.page = page;
        item.last = last;
        pending_refs.push_back(item);
    endtask

    task automatic drain(input int tail);
        int waited;
        waited = 0;
        while ((pending_refs.size() != 0 || s_tvalid || expected_results.size() != 0)
               && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        drain(12);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frames_cfg = value;
        empty_frames();
    endtask

    task automatic random_refs(input int count);
        logic [PAGE_W-1:0] base, page;
        int pool;
        base = PAGE_W'($urandom);
        pool = $urandom_range(1, 11);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                base = PAGE_W'($urandom);
                pool = $urandom_range(1, 11);
            end
            if ($urandom_range(0, 9) == 0)
                page = PAGE_W'($urandom);
            else
                page = base + PAGE_W'($urandom_range(0, pool - 1));
            push_ref(page, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] plan[12];
        plan = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd15, 4'd0, 4'd8, 4'd8};
        frames_cfg = CFG_W'(ACTIVE_RESET);
        empty_frames();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // eight frames after reset: fill, hit, evict, then clear on last
        push_ref(16'h0000, 1'b0);
        push_ref(16'hffff, 1'b0);
        push_ref(16'hffff, 1'b0);
        for (int k = 1; k <= 6; k++)
            push_ref(16'h1000 + 16'(k), 1'b0);
        push_ref(16'h0000, 1'b0);
        push_ref(16'h8000, 1'b0);
        push_ref(16'h1003, 1'b0);
        push_ref(16'h5555, 1'b0);
        push_ref(16'haaaa, 1'b1);
        push_ref(16'h0000, 1'b0);
        push_ref(16'h0000, 1'b1);

        // zero frames behaves as one
        write_frames(4'd0);
        push_ref(16'h0005, 1'b0);
        push_ref(16'h0005, 1'b0);
        push_ref(16'h0006, 1'b0);
        push_ref(16'h0005, 1'b1);

        // frame count above the table size saturates
        write_frames(4'd15);
        for (int k = 0; k < 9; k++)
            push_ref(16'h7f00 + 16'(k), 1'b0);

        for (int p = 0; p < 12; p++) begin
            if (p == 11) begin
                drain(12);
                @(posedge aclk);
                quiet <= 1'b1;
            end
            write_frames((p == 10) ? CFG_W'($urandom_range(0, 15)) : plan[p]);
            random_refs(155);
        end

        drain(20);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected %0d more actual 0", $time,
                     expected_results.size());
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: lru_page_frame_replacer.f
hw/rtl/lpfr_pkg.sv
hw/rtl/lpfr_page_store.sv
hw/rtl/lpfr_recency.sv
hw/rtl/lru_page_frame_replacer.sv
bench/tb_lru_page_frame_replacer.sv
